// ----- rtl/core/sqms_pkg.sv -----
// Shared types and constants of the sine quadrature block.
package sqms_pkg;

   // pi with 30 fraction bits; other widths round this value
   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_BOUND  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT_BOUND = 8'd1;

   // result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_BOUNDS = 2'd1;
   localparam logic [1:0] STAT_ZERO   = 2'd2;

   // Horner divisors of the sine series and their reciprocals
   localparam int HORNER_STEPS = 6;
   localparam int RECIP_SHIFT  = 35;
   localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
      '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [32:0] HORNER_RECIP [HORNER_STEPS] = '{
      33'((64'd1 << RECIP_SHIFT) / 64'd156),
      33'((64'd1 << RECIP_SHIFT) / 64'd110),
      33'((64'd1 << RECIP_SHIFT) / 64'd72),
      33'((64'd1 << RECIP_SHIFT) / 64'd42),
      33'((64'd1 << RECIP_SHIFT) / 64'd20),
      33'((64'd1 << RECIP_SHIFT) / 64'd6)
   };

   // exact floor division of a 32-bit word by three: multiply, then shift
   localparam int          RECIP3_SHIFT = 33;
   localparam logic [32:0] RECIP3       = 33'h0_AAAA_AAAB;

   typedef enum logic [4:0] {
      OP_NOP, OP_START, OP_DIV_STEP, OP_DIV_END, OP_EDGE,
      OP_SIN_LOAD, OP_SIN_SQ, OP_SIN_X2, OP_H_MUL, OP_H_REC, OP_H_FIX,
      OP_SIN_MUL, OP_SIN_OUT, OP_ACC_M, OP_ACC_S, OP_D3_LOAD, OP_D3_STEP,
      OP_D3_FIX, OP_ADVANCE, OP_LOAD_RSP
   } op_type;

   typedef enum logic [1:0] {
      ROLE_LEFT, ROLE_MID, ROLE_RIGHT
   } role_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] k_idx;
      role_type   role;
   } cmd_type;

   typedef struct packed {
      logic bad_bounds;
      logic zero_count;
      logic last_panel;
   } stat_type;

endpackage

// ----- rtl/core/sqms_datapath.sv -----
// Datapath: bounds, divider, shared multiplier, sine series, accumulators.
module sqms_datapath #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sqms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                          csr_wdata,
   input  logic [COUNT_BITS-1:0]                req_partition_count,
   input  sqms_pkg::cmd_type                    cmd,
   output sqms_pkg::stat_type                   stat,
   output logic [31:0]                          rsp_midpoint_integral,
   output logic [31:0]                          rsp_simpson_integral,
   output logic [1:0]                           rsp_status
);
   import sqms_pkg::*;

   localparam logic [31:0] PI_Q =
      32'((64'(PI_Q30) + ((64'd1 << (30 - FRAC_BITS)) >> 1)) >> (30 - FRAC_BITS));
   localparam logic [31:0] HALF_PI = PI_Q >> 1;
   localparam logic [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);

   logic [31:0]           left_ff, right_ff;
   logic [COUNT_BITS-1:0] n_ff, i_ff, r_ff, rem_ff, div_rem_ff;
   logic [31:0]           q_ff, x_ff, nx_ff, w_ff;
   logic [31:0]           sx_ff, x2_ff, t_ff, p_ff;
   logic [31:0]           sl_ff, sm_ff, sr_ff;
   logic [63:0]           prod_ff, acc_mid_ff, acc_simp_ff, d3_ff;
   logic [31:0]           hq_ff, wq_ff;
   logic [1:0]            status_ff;

   // bounds
   logic [31:0] a_clamp, b_clamp, span;
   assign a_clamp = (left_ff > PI_Q) ? PI_Q : left_ff;
   assign b_clamp = (right_ff > PI_Q) ? PI_Q : right_ff;
   assign span    = b_clamp - a_clamp;

   // restoring divider step: one quotient bit per beat
   logic [COUNT_BITS:0]   div_trial;
   logic                  div_ge;
   logic [COUNT_BITS-1:0] div_rem_in;
   assign div_trial  = {div_rem_ff, q_ff[31]};
   assign div_ge     = div_trial >= {1'b0, n_ff};
   assign div_rem_in = div_ge ? COUNT_BITS'(div_trial - {1'b0, n_ff})
                              : div_trial[COUNT_BITS-1:0];

   // next panel edge
   logic [COUNT_BITS:0]   rem_sum;
   logic                  edge_inc;
   logic [COUNT_BITS-1:0] rem_in;
   logic [31:0]           w_in;
   assign rem_sum  = {1'b0, rem_ff} + {1'b0, r_ff};
   assign edge_inc = rem_sum >= {1'b0, n_ff};
   assign rem_in   = edge_inc ? COUNT_BITS'(rem_sum - {1'b0, n_ff})
                              : rem_sum[COUNT_BITS-1:0];
   assign w_in     = q_ff + 32'(edge_inc);

   // sine argument: select, clamp to pi, fold about pi/2
   logic [31:0] ang, ang_c, ang_f;
   always_comb begin
      unique case (cmd.role)
         ROLE_LEFT:  ang = x_ff;
         ROLE_MID:   ang = x_ff + (w_ff >> 1);
         ROLE_RIGHT: ang = nx_ff;
         default:    ang = x_ff;
      endcase
      ang_c = (ang > PI_Q) ? PI_Q : ang;
      ang_f = (ang_c > HALF_PI) ? (PI_Q - ang_c) : ang_c;
   end

   // shared multiplier
   logic [31:0] prod_shift;
   logic [34:0] sum3;
   logic [31:0] half_sum;
   logic [31:0] mul_a;
   logic [32:0] mul_b;
   logic [64:0] mul_full;
   assign prod_shift = prod_ff[FRAC_BITS +: 32];
   assign sum3       = 35'(sl_ff) + (35'(sm_ff) << 2) + 35'(sr_ff);
   assign half_sum   = sum3[32:1];

   always_comb begin
      unique case (cmd.op)
         OP_SIN_SQ: begin mul_a = sx_ff;      mul_b = 33'(sx_ff); end
         OP_H_MUL:  begin mul_a = x2_ff;      mul_b = 33'(t_ff); end
         OP_H_REC:  begin mul_a = prod_shift; mul_b = HORNER_RECIP[cmd.k_idx]; end
         OP_SIN_MUL: begin mul_a = sx_ff;     mul_b = 33'(t_ff); end
         OP_ACC_M:  begin mul_a = w_ff;       mul_b = 33'(sm_ff); end
         OP_ACC_S:  begin mul_a = half_sum;   mul_b = RECIP3; end
         OP_D3_LOAD: begin mul_a = w_ff;      mul_b = RECIP3; end
         OP_D3_STEP: begin mul_a = w_ff;      mul_b = 33'(hq_ff); end
         default:   begin mul_a = '0;         mul_b = '0; end
      endcase
   end
   assign mul_full = 65'(mul_a) * 65'(mul_b);

   // reciprocal quotient with one correction
   logic [31:0] q0, qq, t_in;
   logic [39:0] q0k, rr;
   always_comb begin
      q0   = 32'(prod_ff[63:RECIP_SHIFT]);
      q0k  = 40'(q0) * 40'(HORNER_DIV[cmd.k_idx]);
      rr   = 40'(p_ff) - q0k;
      qq   = q0 + 32'(rr >= 40'(HORNER_DIV[cmd.k_idx]));
      t_in = ONE_Q - qq;
   end

   // divide w * half_sum by three: split both factors into a multiple of
   // three and a rest of 0 to 2; only the two low bits of each rest matter
   logic [1:0]  hq3_lo, hr_lo, wq3_lo, wr_lo;
   logic [32:0] wq_hr;
   logic        d3_carry;
   always_comb begin
      hq3_lo = {hq_ff[0], 1'b0} + hq_ff[1:0];
      hr_lo  = half_sum[1:0] - hq3_lo;
      wq3_lo = {wq_ff[0], 1'b0} + wq_ff[1:0];
      wr_lo  = w_ff[1:0] - wq3_lo;
      unique case (hr_lo)
         2'd1:    wq_hr = 33'(wq_ff);
         2'd2:    wq_hr = {wq_ff, 1'b0};
         default: wq_hr = '0;
      endcase
      d3_carry = (wr_lo == 2'd2) && (hr_lo == 2'd2);
   end

   // sine result and saturated outputs
   logic [31:0] sine_val;
   logic [63:0] mid_hi, simp_hi;
   assign sine_val = (prod_shift > ONE_Q) ? ONE_Q : prod_shift;
   assign mid_hi   = acc_mid_ff >> FRAC_BITS;
   assign simp_hi  = acc_simp_ff >> FRAC_BITS;

   assign stat.bad_bounds = left_ff >= right_ff;
   assign stat.zero_count = req_partition_count == '0;
   assign stat.last_panel = i_ff == (n_ff - COUNT_BITS'(1));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= PI_Q30;
      end else if (csr_we) begin
         if (csr_index == REG_LEFT_BOUND)  left_ff  <= csr_wdata;
         if (csr_index == REG_RIGHT_BOUND) right_ff <= csr_wdata;
      end
   end

   // execute one command per beat
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_START: begin
            n_ff        <= req_partition_count;
            i_ff        <= '0;
            q_ff        <= span;
            div_rem_ff  <= '0;
            x_ff        <= a_clamp;
            acc_mid_ff  <= '0;
            acc_simp_ff <= '0;
            status_ff   <= stat.bad_bounds ? STAT_BOUNDS
                         : (stat.zero_count ? STAT_ZERO : STAT_OK);
         end
         OP_DIV_STEP: begin
            div_rem_ff <= div_rem_in;
            q_ff       <= {q_ff[30:0], div_ge};
         end
         OP_DIV_END: begin
            r_ff   <= div_rem_ff;
            rem_ff <= '0;
         end
         OP_EDGE: begin
            rem_ff <= rem_in;
            w_ff   <= w_in;
            nx_ff  <= x_ff + w_in;
         end
         OP_SIN_LOAD: sx_ff <= ang_f;
         OP_SIN_SQ:   prod_ff <= mul_full[63:0];
         OP_SIN_X2: begin
            x2_ff <= prod_shift;
            t_ff  <= ONE_Q;
         end
         OP_H_MUL: prod_ff <= mul_full[63:0];
         OP_H_REC: begin
            p_ff    <= prod_shift;
            prod_ff <= mul_full[63:0];
         end
         OP_H_FIX:   t_ff <= t_in;
         OP_SIN_MUL: prod_ff <= mul_full[63:0];
         OP_SIN_OUT: begin
            unique case (cmd.role)
               ROLE_LEFT:  sl_ff <= sine_val;
               ROLE_MID:   sm_ff <= sine_val;
               ROLE_RIGHT: sr_ff <= sine_val;
               default:    sl_ff <= sine_val;
            endcase
         end
         OP_ACC_M: prod_ff <= mul_full[63:0];
         OP_ACC_S: begin
            acc_mid_ff <= acc_mid_ff + prod_ff;
            prod_ff    <= mul_full[63:0];
         end
         OP_D3_LOAD: begin
            hq_ff   <= 32'(prod_ff[63:RECIP3_SHIFT]);
            prod_ff <= mul_full[63:0];
         end
         OP_D3_STEP: begin
            wq_ff   <= 32'(prod_ff[63:RECIP3_SHIFT]);
            prod_ff <= mul_full[63:0];
         end
         OP_D3_FIX: d3_ff <= prod_ff + 64'(wq_hr) + 64'(d3_carry);
         OP_ADVANCE: begin
            acc_simp_ff <= acc_simp_ff + d3_ff;
            sl_ff       <= sr_ff;
            x_ff        <= nx_ff;
            i_ff        <= i_ff + COUNT_BITS'(1);
         end
         OP_LOAD_RSP: begin
            rsp_midpoint_integral <= (|mid_hi[63:32]) ? '1 : mid_hi[31:0];
            rsp_simpson_integral  <= (|simp_hi[63:32]) ? '1 : simp_hi[31:0];
            rsp_status            <= status_ff;
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/sqms_ctrl.sv -----
// Controller: sequences division, sine series and panel accumulation.
module sqms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sqms_pkg::stat_type stat,
   output sqms_pkg::cmd_type  cmd
);
   import sqms_pkg::*;

   localparam logic [4:0] DIV_LAST = 5'd31;
   localparam logic [2:0] K_LAST   = 3'(HORNER_STEPS - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIV, ST_DIV_END, ST_SIN_LOAD, ST_SIN_SQ, ST_SIN_X2,
      ST_H_MUL, ST_H_REC, ST_H_FIX, ST_SIN_MUL, ST_SIN_OUT, ST_EDGE,
      ST_ACC_M, ST_ACC_S, ST_D3_LOAD, ST_D3_STEP, ST_D3_FIX, ST_ADVANCE, ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [2:0] k_ff, k_in;
   role_type   role_ff, role_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, load;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      role_in      = role_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      cmd.k_idx    = k_ff;
      cmd.role     = role_ff;
      cmd.op       = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op = OP_START;
               cnt_in = '0;
               state_in = (stat.bad_bounds || stat.zero_count) ? ST_OUT : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.op   = OP_DIV_END;
            role_in  = ROLE_LEFT;
            state_in = ST_SIN_LOAD;
         end
         ST_SIN_LOAD: begin cmd.op = OP_SIN_LOAD; state_in = ST_SIN_SQ; end
         ST_SIN_SQ:   begin cmd.op = OP_SIN_SQ;   state_in = ST_SIN_X2; end
         ST_SIN_X2: begin
            cmd.op   = OP_SIN_X2;
            k_in     = '0;
            state_in = ST_H_MUL;
         end
         ST_H_MUL: begin cmd.op = OP_H_MUL; state_in = ST_H_REC; end
         ST_H_REC: begin cmd.op = OP_H_REC; state_in = ST_H_FIX; end
         ST_H_FIX: begin
            cmd.op = OP_H_FIX;
            if (k_ff == K_LAST) begin
               state_in = ST_SIN_MUL;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_H_MUL;
            end
         end
         ST_SIN_MUL: begin cmd.op = OP_SIN_MUL; state_in = ST_SIN_OUT; end
         ST_SIN_OUT: begin
            cmd.op = OP_SIN_OUT;
            unique case (role_ff)
               ROLE_LEFT:  state_in = ST_EDGE;
               ROLE_MID: begin
                  role_in  = ROLE_RIGHT;
                  state_in = ST_SIN_LOAD;
               end
               ROLE_RIGHT: state_in = ST_ACC_M;
               default:    state_in = ST_EDGE;
            endcase
         end
         ST_EDGE: begin
            cmd.op   = OP_EDGE;
            role_in  = ROLE_MID;
            state_in = ST_SIN_LOAD;
         end
         ST_ACC_M:   begin cmd.op = OP_ACC_M;   state_in = ST_ACC_S; end
         ST_ACC_S:   begin cmd.op = OP_ACC_S;   state_in = ST_D3_LOAD; end
         ST_D3_LOAD: begin cmd.op = OP_D3_LOAD; state_in = ST_D3_STEP; end
         ST_D3_STEP: begin cmd.op = OP_D3_STEP; state_in = ST_D3_FIX; end
         ST_D3_FIX:  begin cmd.op = OP_D3_FIX;  state_in = ST_ADVANCE; end
         ST_ADVANCE: begin
            cmd.op   = OP_ADVANCE;
            state_in = stat.last_panel ? ST_OUT : ST_EDGE;
         end
         ST_OUT: begin
            if (load) begin
               cmd.op   = OP_LOAD_RSP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         role_ff      <= ROLE_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         role_ff      <= role_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/sine_quadrature_midpoint_simpson.sv -----
// Top level: midpoint and Simpson integration of sine over a set interval.
//
//   channel   ports                                   direction
//   req       req_valid/ready, req_partition_count    in
//   rsp       rsp_valid/ready, rsp_*_integral, status out
//   csr       csr_valid/ready, csr_index, csr_wdata   in
//
// One item runs a restoring divider, a sine of the left edge and the result load,
// then per panel an edge step, two sine evaluations on the one shared multiplier
// and the accumulation steps with a divide by three by reciprocal multiplication.
// Bad bounds or zero panels skip the divider and go straight to the result load.
// Reset (synchronous) returns to idle and restores the bound registers.
// A finished result waits in the output register while the next beat enters.
module sine_quadrature_midpoint_simpson #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COUNT_BITS-1:0]               req_partition_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         rsp_midpoint_integral,
   output logic [31:0]                         rsp_simpson_integral,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sqms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_wdata
);
   import sqms_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sqms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sqms_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_partition_count   (req_partition_count),
      .cmd                   (cmd),
      .stat                  (stat),
      .rsp_midpoint_integral (rsp_midpoint_integral),
      .rsp_simpson_integral  (rsp_simpson_integral),
      .rsp_status            (rsp_status)
   );

endmodule

// ----- rtl/core/sqms_checker.sv -----
// Port-level checks of the sine quadrature block, bound to its top level.
module sqms_checker #(
   parameter int COUNT_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [COUNT_BITS-1:0]               req_partition_count,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [31:0]                         rsp_midpoint_integral,
   input logic [31:0]                         rsp_simpson_integral,
   input logic [1:0]                          rsp_status,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [sqms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [31:0]                         csr_wdata
);
   import sqms_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_midpoint_integral)
         && $stable(rsp_simpson_integral) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again without a gap");

   // error results carry zero integrals
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_BOUNDS || rsp_status == STAT_ZERO)
         |-> rsp_midpoint_integral == '0 && rsp_simpson_integral == '0)
      else $error("error result with nonzero integral");

   // status is a defined code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_BOUNDS
         || rsp_status == STAT_ZERO)
      else $error("undefined status code");

endmodule

bind sine_quadrature_midpoint_simpson sqms_checker #(.COUNT_BITS(COUNT_BITS)) u_sqms_checker (.*);

// ----- sim/sine_quadrature_midpoint_simpson_test.sv -----
// Testbench for sine_quadrature_midpoint_simpson: directed table plus random panel counts.
`timescale 1ns / 100ps

module sine_quadrature_midpoint_simpson_test;
   import sqms_pkg::*;

   localparam logic [63:0] PI_FIX = 64'd3373259426;
   localparam logic [63:0] ONE_FIX = 64'd1 << 30;
   localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] mid;
      logic [31:0] simp;
      logic [1:0]  stat;
   } integral_t;

   typedef struct {
      logic [15:0] count;
      logic        typed;
      integral_t   value;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_partition_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_midpoint_integral;
   logic [31:0] rsp_simpson_integral;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   sine_quadrature_midpoint_simpson dut (.*);

   // model copy of the bound registers
   logic [63:0] lo_bound, hi_bound;
   integral_t   pending_integrals[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #1000ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [63:0] sine_fix(input logic [63:0] ang);
      logic [63:0] x, x2, t, s;
      logic [63:0] divs[6];
      divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      x = (ang > PI_FIX) ? PI_FIX : ang;
      if (x > (PI_FIX >> 1)) x = PI_FIX - x;
      x2 = (x * x) >> 30;
      t = ONE_FIX;
      for (int k = 0; k < 6; k++) t = ONE_FIX - ((x2 * t) >> 30) / divs[k];
      s = (x * t) >> 30;
      if (s > ONE_FIX) s = ONE_FIX;
      return s;
   endfunction

   function automatic integral_t integrate_sine(input logic [15:0] count);
      integral_t   res;
      logic [63:0] n, a, b, span, q, r, rem, x, nx, w, sl, sm, sr, am, asum;
      res = '0;
      n = 64'(count);
      if (lo_bound >= hi_bound) begin
         res.stat = STAT_BOUNDS;
         return res;
      end
      if (n == 0) begin
         res.stat = STAT_ZERO;
         return res;
      end
      a = (lo_bound > PI_FIX) ? PI_FIX : lo_bound;
      b = (hi_bound > PI_FIX) ? PI_FIX : hi_bound;
      span = b - a;
      q = span / n;
      r = span % n;
      rem = 0;
      x = a;
      sl = sine_fix(a);
      am = 0;
      asum = 0;
      for (logic [63:0] i = 0; i < n; i++) begin
         nx = x + q;
         rem += r;
         if (rem >= n) begin
            rem -= n;
            nx++;
         end
         w = nx - x;
         sm = sine_fix(x + (w >> 1));
         sr = sine_fix(nx);
         am += w * sm;
         asum += (w * ((sl + 4 * sm + sr) >> 1)) / 3;
         sl = sr;
         x = nx;
      end
      am = am >> 30;
      asum = asum >> 30;
      res.mid = (am > WORD_MAX) ? WORD_MAX[31:0] : am[31:0];
      res.simp = (asum > WORD_MAX) ? WORD_MAX[31:0] : asum[31:0];
      res.stat = STAT_OK;
      return res;
   endfunction

   // result side: random stall, compare each beat with the oldest expectation
   always @(posedge clock) begin
      integral_t got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_midpoint_integral, rsp_simpson_integral, rsp_status};
         results_seen++;
         if (pending_integrals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
         end else begin
            want = pending_integrals.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected mid %h simp %h stat %0d, got mid %h simp %h stat %0d",
                           want.mid, want.simp, want.stat, got.mid, got.simp, got.stat);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_bound(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_LEFT_BOUND) lo_bound = 64'(val);
      else hi_bound = 64'(val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold until all results are in, then let a finishing item drain
   task automatic drain_results();
      while (pending_integrals.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_count(input logic [15:0] count, input logic typed, input integral_t value);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      @(negedge clock);
      req_valid <= 1'b1;
      req_partition_count <= count;
      do @(posedge clock); while (!req_ready);
      pending_integrals.push_back(typed ? value : integrate_sine(count));
      items_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
      drain_results();
      write_bound(REG_LEFT_BOUND, lo);
      write_bound(REG_RIGHT_BOUND, hi);
   endtask

   initial begin
      row_t        rows[$];
      logic [31:0] lo, hi;
      lo_bound = 0;
      hi_bound = PI_FIX;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset bounds [0, pi]
      rows = '{
         '{16'd0,     1'b1, '{32'd0, 32'd0, STAT_ZERO}},
         '{16'd1,     1'b0, '0},
         '{16'd2,     1'b0, '0},
         '{16'd3,     1'b0, '0},
         '{16'd8,     1'b0, '0},
         '{16'd255,   1'b0, '0},
         '{16'd1000,  1'b0, '0},
         '{16'hAAAA,  1'b0, '0},
         '{16'hFFFF,  1'b0, '0}
      };
      foreach (rows[i]) send_count(rows[i].count, rows[i].typed, rows[i].value);

      // bad bounds: equal, then reversed
      set_bounds(32'd1000, 32'd1000);
      send_count(16'd5, 1'b1, '{32'd0, 32'd0, STAT_BOUNDS});
      send_count(16'd0, 1'b1, '{32'd0, 32'd0, STAT_BOUNDS});
      set_bounds(32'hFFFF_FFFF, 32'd0);
      send_count(16'd7, 1'b1, '{32'd0, 32'd0, STAT_BOUNDS});
      // wholly above pi, and straddling pi
      set_bounds(32'hD000_0000, 32'hFFFF_FFFF);
      send_count(16'd4, 1'b1, '{32'd0, 32'd0, STAT_OK});
      set_bounds(32'd1, 32'hFFFF_FFFF);
      send_count(16'd5, 1'b0, '0);
      send_count(16'h5555, 1'b0, '0);

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 38 : 0;
         recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 38 : 0;
         for (int j = 0; j < 38; j++) begin
            if (j % 12 == 0) begin
               lo = $urandom_range(3373259426);
               hi = $urandom_range(3373259426);
               if ($urandom_range(9) == 0) hi = $urandom;
               if ($urandom_range(9) == 0) lo = hi;
               set_bounds(lo, hi);
            end
            if ($urandom_range(19) == 0) send_count(16'd0, 1'b0, '0);
            else if ($urandom_range(29) == 0)
               send_count(16'($urandom_range(41, 2000)), 1'b0, '0);
            else send_count(16'($urandom_range(1, 40)), 1'b0, '0);
         end
      end

      drain_results();
      $display("sent %0d panel counts, checked %0d results over several bound settings",
               items_sent, results_seen);
      if (mismatches == 0 && pending_integrals.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
